[hw/rtl/tfd_pkg.sv]
// Shared types and constants of the trace frame deformatter.
package tfd_pkg;

	localparam int NUM_CHANNELS = 4;

	localparam int WORD_W  = 32;
	localparam int BYTE_W  = 8;
	localparam int ID_W    = 7;
	localparam int CHAN_W  = 2;
	localparam int FRAME_W = 4 * WORD_W;

	localparam logic [WORD_W-1:0] ALL_ONES = '1;
	localparam logic [ID_W-1:0]   ID_RESET = ID_W'(5);

	// frame and result queues are both two deep
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	typedef logic [FRAME_W-1:0] frame_t;

	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_ID_ZERO  = 2'd1,
		KIND_ID_OTHER = 2'd2,
		KIND_FAULT    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [BYTE_W-1:0]  data_byte;
		logic [CHAN_W-1:0]  channel;
		logic [ID_W-1:0]    source_id;
		logic               last;
	} res_t;

endpackage

[hw/rtl/trace_frame_deformatter_core.sv]
// Top level of the trace frame deformatter.
// Takes 32-bit trace FIFO words, skips all-ones filler words, and turns every
// four kept words into a 16-byte frame whose data bytes come out one result
// per request, tagged with kind, channel and source ID; the last result of a
// frame has last set. An auxiliary fault (ID change in slot 7 with its aux bit
// set) gives one fault result and then all further words are ignored until
// reset. Words are taken one per cycle while the two-entry frame queue has
// room. The back-end sequencer takes one frame at a time, the next only after
// the last result of the current one, and emits at most one result per cycle
// while the result queue has room; results leave through a two-entry queue.
module trace_frame_deformatter_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [tfd_pkg::WORD_W-1:0]  word,
	output logic                        empty,
	input  logic                        pop,
	output logic [1:0]                  kind,
	output logic [tfd_pkg::BYTE_W-1:0]  data_byte,
	output logic [tfd_pkg::CHAN_W-1:0]  channel,
	output logic [tfd_pkg::ID_W-1:0]    source_id,
	output logic                        last
);
	import tfd_pkg::*;

	logic   fq_push, fq_pop, fq_full, fq_empty;
	frame_t fq_wr_frame, fq_rd_frame;
	logic   oq_push, oq_full;
	res_t   oq_wr_res, oq_rd_res;

	assign full = fq_full;

	tfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.word     (word),
		.fq_full  (fq_full),
		.fq_push  (fq_push),
		.fq_frame (fq_wr_frame)
	);

	tfd_frame_q u_frame_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fq_push),
		.wr_frame (fq_wr_frame),
		.pop      (fq_pop),
		.full     (fq_full),
		.empty    (fq_empty),
		.rd_frame (fq_rd_frame)
	);

	tfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.fq_empty (fq_empty),
		.fq_frame (fq_rd_frame),
		.fq_pop   (fq_pop),
		.oq_full  (oq_full),
		.oq_push  (oq_push),
		.oq_res   (oq_wr_res)
	);

	tfd_out_q u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (oq_push),
		.wr_res (oq_wr_res),
		.pop    (pop),
		.full   (oq_full),
		.empty  (empty),
		.rd_res (oq_rd_res)
	);

	assign kind      = oq_rd_res.kind;
	assign data_byte = oq_rd_res.data_byte;
	assign channel   = oq_rd_res.channel;
	assign source_id = oq_rd_res.source_id;
	assign last      = oq_rd_res.last;

endmodule

[hw/rtl/tfd_front.sv]
// Front end: drops filler words, assembles 16-byte frames, flags aux faults.
module tfd_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [tfd_pkg::WORD_W-1:0] word,
	input  logic                   fq_full,
	output logic                   fq_push,
	output tfd_pkg::frame_t        fq_frame
);
	import tfd_pkg::*;

	logic [WORD_W-1:0] frame_words_q [3];
	logic [1:0]        word_cnt_q;
	logic              stuck_q;
	logic              keep;
	logic              fault_frame;

	assign keep     = push && !fq_full && !stuck_q && (word != ALL_ONES);
	assign fq_push  = keep && (word_cnt_q == 2'd3);
	assign fq_frame = {word, frame_words_q[2], frame_words_q[1], frame_words_q[0]};
	// ID change in slot 7 with aux bit 7 set
	assign fault_frame = fq_frame[112] && fq_frame[127];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_cnt_q <= 2'd0;
			stuck_q    <= 1'b0;
		end else if (keep) begin
			word_cnt_q <= word_cnt_q + 2'd1;
			if (fq_push && fault_frame) begin
				stuck_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (keep && word_cnt_q != 2'd3) begin
			frame_words_q[word_cnt_q] <= word;
		end
	end

	a_stuck_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(stuck_q)) else $error("fault stuck flag cleared without reset");
	a_no_push_stuck: assert property (@(posedge clk) disable iff (!arst_n)
		stuck_q |-> !fq_push) else $error("frame pushed while stuck");
	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		fq_push |-> !fq_full) else $error("frame pushed into full queue");

endmodule

[hw/rtl/tfd_frame_q.sv]
// Two-entry frame queue between front and back ends.
module tfd_frame_q (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tfd_pkg::frame_t wr_frame,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output tfd_pkg::frame_t rd_frame
);
	import tfd_pkg::*;

	frame_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full     = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_frame = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_frame;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH)) else $error("frame queue overflow");
	a_ptr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == Q_CNT_W'(Q_DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("frame queue pointers disagree with count");

endmodule

[hw/rtl/tfd_back.sv]
// Back end: walks a frame slot by slot, one result per cycle while the result queue has room, tracks source ID.
module tfd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fq_empty,
	input  tfd_pkg::frame_t fq_frame,
	output logic            fq_pop,
	input  logic            oq_full,
	output logic            oq_push,
	output tfd_pkg::res_t   oq_res
);
	import tfd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EVEN = 3'b010,
		ST_ODD  = 3'b100
	} state_t;

	state_t            state_q, state_d;
	frame_t            frame_q;
	logic [2:0]        slot_q, slot_d;
	logic [ID_W-1:0]   id_q, id_d;

	logic [6:0]        base;
	logic [BYTE_W-1:0] ev, od, ev7, aux;
	logic              ab, chg, skip7, go, end_slot;
	logic [ID_W-1:0]   emit_id;
	logic [BYTE_W-1:0] emit_data;
	logic              emit_fault, emit_last;

	assign base  = {slot_q, 4'd0};
	assign ev    = frame_q[base +: BYTE_W];
	assign od    = frame_q[(base + 7'd8) +: BYTE_W];
	assign aux   = frame_q[127:120];
	assign ev7   = frame_q[119:112];
	assign ab    = aux[slot_q];
	assign chg   = ev[0];
	// slot 7 with an ID change and clear aux yields no result
	assign skip7 = ev7[0] && !aux[7];
	assign go    = !oq_full;

	assign fq_pop = (state_q == ST_IDLE) && !fq_empty;

	always_comb begin
		state_d    = state_q;
		slot_d     = slot_q;
		id_d       = id_q;
		oq_push    = 1'b0;
		emit_id    = id_q;
		emit_data  = od;
		emit_fault = 1'b0;
		emit_last  = 1'b0;
		end_slot   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!fq_empty) begin
					state_d = ST_EVEN;
					slot_d  = 3'd0;
				end
			end
			ST_EVEN: begin
				if (go) begin
					oq_push = 1'b1;
					if (chg && ab && slot_q == 3'd7) begin
						emit_fault = 1'b1;
						emit_data  = '0;
						emit_last  = 1'b1;
						state_d    = ST_IDLE;
					end else if (chg) begin
						emit_id  = ab ? id_q : ev[7:1];
						id_d     = ev[7:1];
						end_slot = 1'b1;
					end else begin
						emit_data = {ev[7:1], ab};
						if (slot_q == 3'd7) begin
							emit_last = 1'b1;
							state_d   = ST_IDLE;
						end else begin
							state_d = ST_ODD;
						end
					end
				end
			end
			ST_ODD: begin
				if (go) begin
					oq_push  = 1'b1;
					end_slot = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (end_slot) begin
			if (slot_q == 3'd6 && skip7) begin
				emit_last = 1'b1;
				id_d      = ev7[7:1];
				state_d   = ST_IDLE;
			end else begin
				slot_d  = slot_q + 3'd1;
				state_d = ST_EVEN;
			end
		end
	end

	always_comb begin
		oq_res.data_byte = emit_data;
		oq_res.source_id = emit_id;
		oq_res.last      = emit_last;
		oq_res.channel   = '0;
		if (emit_fault) begin
			oq_res.kind = KIND_FAULT;
		end else if (emit_id == '0) begin
			oq_res.kind = KIND_ID_ZERO;
		end else if (emit_id <= ID_W'(NUM_CHANNELS)) begin
			oq_res.kind    = KIND_DATA;
			oq_res.channel = CHAN_W'(emit_id - ID_W'(1));
		end else begin
			oq_res.kind = KIND_ID_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
			id_q    <= ID_RESET;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
			id_q    <= id_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fq_pop) begin
			frame_q <= fq_frame;
		end
	end

	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		oq_push |-> !oq_full) else $error("result pushed into full queue");
	a_fault_last: assert property (@(posedge clk) disable iff (!arst_n)
		(oq_push && oq_res.kind == KIND_FAULT) |-> oq_res.last)
		else $error("fault result not marked last");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(oq_push && oq_res.last) |=> (state_q == ST_IDLE))
		else $error("sequencer kept running after last result");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fq_pop |=> (state_q == ST_EVEN && slot_q == 3'd0))
		else $error("frame load did not start at slot 0");

endmodule

[hw/rtl/tfd_out_q.sv]
// Two-entry result queue that drives the output ports.
module tfd_out_q (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tfd_pkg::res_t wr_res,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output tfd_pkg::res_t rd_res
);
	import tfd_pkg::*;

	res_t                 mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_res  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_res;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH)) else $error("result queue overflow");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (cnt_q == $past(cnt_q) - Q_CNT_W'(1)))
		else $error("result queue count did not drop on pop");

endmodule

[dv/testbench.sv]
// Self-checking testbench for the trace frame deformatter core.
`timescale 1ns / 1ps

module testbench;
	import tfd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	logic [WORD_W-1:0]   word;
	logic                empty;
	logic                pop;
	logic [1:0]          kind;
	logic [BYTE_W-1:0]   data_byte;
	logic [CHAN_W-1:0]   channel;
	logic [ID_W-1:0]     source_id;
	logic                last;

	trace_frame_deformatter_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.word      (word),
		.empty     (empty),
		.pop       (pop),
		.kind      (kind),
		.data_byte (data_byte),
		.channel   (channel),
		.source_id (source_id),
		.last      (last)
	);

	// deformatter state mirror
	logic [WORD_W-1:0] held_frame [3];
	int                held_words;
	logic [ID_W-1:0]   cur_id;
	bit                stuck;

	res_t expected_results [$];
	res_t got_res;
	res_t want_res;

	int fail_count;
	int cycle_count;
	int hold_off;
	int stall_left;
	bit idle_en;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time, expected_results.size());
			$display("testbench NOT OK");
			$finish;
		end
	end

	function automatic void add_result(kind_t k, logic [BYTE_W-1:0] d, logic [ID_W-1:0] id);
		res_t r;
		logic [ID_W-1:0] idm;
		idm = id - 7'd1;
		r.kind = k;
		r.data_byte = d;
		r.channel = (k == KIND_DATA) ? idm[CHAN_W-1:0] : '0;
		r.source_id = id;
		r.last = 1'b0;
		expected_results.push_back(r);
	endfunction

	function automatic void note_byte(logic [BYTE_W-1:0] d);
		if (cur_id == '0)
			add_result(KIND_ID_ZERO, d, cur_id);
		else if (cur_id <= NUM_CHANNELS)
			add_result(KIND_DATA, d, cur_id);
		else
			add_result(KIND_ID_OTHER, d, cur_id);
	endfunction

	function automatic void predict_word(logic [WORD_W-1:0] w);
		logic [BYTE_W-1:0] fb [16];
		logic [BYTE_W-1:0] aux;
		logic [BYTE_W-1:0] ev;
		logic [BYTE_W-1:0] od;
		logic [WORD_W-1:0] v;
		int base;
		if (stuck || w == ALL_ONES)
			return;
		if (held_words < 3) begin
			held_frame[held_words] = w;
			held_words++;
			return;
		end
		held_words = 0;
		for (int k = 0; k < 4; k++) begin
			v = (k < 3) ? held_frame[k] : w;
			for (int j = 0; j < 4; j++)
				fb[4*k + j] = v[8*j +: 8];
		end
		aux = fb[15];
		base = expected_results.size();
		for (int s = 0; s < 8; s++) begin
			ev = fb[2*s];
			od = fb[2*s + 1];
			if (ev[0] && aux[s]) begin
				if (s == 7) begin
					add_result(KIND_FAULT, 8'h00, cur_id);
					stuck = 1'b1;
					break;
				end
				// odd byte still belongs to the old ID
				note_byte(od);
				cur_id = ev[7:1];
			end else if (ev[0]) begin
				cur_id = ev[7:1];
				if (s != 7)
					note_byte(od);
			end else begin
				note_byte({ev[7:1], aux[s]});
				if (s != 7)
					note_byte(od);
			end
		end
		if (expected_results.size() > base)
			expected_results[expected_results.size() - 1].last = 1'b1;
	endfunction

	// keeps random traffic away from the slot 7 aux fault, which would end the run early
	function automatic logic [WORD_W-1:0] fault_safe(logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] r;
		r = w;
		if (!stuck && held_words == 3 && r != ALL_ONES && r[31] && r[16])
			r[16] = 1'b0;
		return r;
	endfunction

	function automatic void random_frame(output logic [BYTE_W-1:0] fb [16]);
		logic [ID_W-1:0] id;
		for (int s = 0; s < 8; s++) begin
			if ($urandom_range(0, 2) == 0) begin
				id = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 6));
				fb[2*s] = {id, 1'b1};
			end else begin
				fb[2*s] = 8'($urandom) & 8'hFE;
			end
			fb[2*s + 1] = 8'($urandom);
		end
	endfunction

	task automatic send_word(input logic [WORD_W-1:0] w);
		int gap;
		@(negedge clk);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		word <= w;
		do
			@(posedge clk);
		while (full);
		predict_word(w);
	endtask

	task automatic release_push();
		@(negedge clk);
		push <= 1'b0;
	endtask

	task automatic send_frame(input logic [BYTE_W-1:0] fb [16], input bit guard);
		logic [WORD_W-1:0] w;
		for (int k = 0; k < 4; k++) begin
			w = {fb[4*k + 3], fb[4*k + 2], fb[4*k + 1], fb[4*k]};
			if (guard)
				w = fault_safe(w);
			send_word(w);
		end
	endtask

	task automatic wait_results_done();
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// receiver: long hold-off when asked, otherwise random stall bursts
	initial begin
		pop = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				pop <= 1'b0;
				hold_off--;
			end else if (idle_en && stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
				if (idle_en && $urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 10);
			end
		end
	end

	function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			got_res = {kind, data_byte, channel, source_id, last};
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got_res);
				fail_count++;
			end else begin
				want_res = expected_results.pop_front();
				check_field("kind", want_res.kind, got_res.kind);
				check_field("data_byte", want_res.data_byte, got_res.data_byte);
				check_field("channel", want_res.channel, got_res.channel);
				check_field("source_id", want_res.source_id, got_res.source_id);
				check_field("last", want_res.last, got_res.last);
			end
		end
	end

	// reset ID 5 is outside the channel range, so every byte comes out as an other-ID result
	task automatic test_plain_data();
		repeat (4) send_word(32'h0000_0000);
		release_push();
	endtask

	task automatic test_filler_words();
		send_word(ALL_ONES);
		send_word(32'h8000_0000);
		send_word(ALL_ONES);
		send_word(32'h0000_0001);
		send_word(32'h7FFF_FFFF);
		send_word(ALL_ONES);
		send_word(32'h7FFE_FFFE);
		release_push();
	endtask

	// ID changes with both aux settings, IDs 0..4 and 127, slot 7 change without emission
	task automatic test_id_changes();
		logic [BYTE_W-1:0] fb [16];
		fb = '{8'h03, 8'hFF, 8'h05, 8'h11, 8'hFE, 8'h00, 8'h01, 8'h22,
		       8'h07, 8'h33, 8'h09, 8'h44, 8'hFF, 8'h55, 8'h0B, 8'h16};
		send_frame(fb, 1'b0);
		fb = '{8'h05, 8'hA5, 8'h00, 8'h5A, 8'h07, 8'h01, 8'h09, 8'h80,
		       8'h03, 8'h7F, 8'h00, 8'h00, 8'h01, 8'hC3, 8'h00, 8'h0F};
		send_frame(fb, 1'b0);
		release_push();
	endtask

	// aux bits replace bit 0 of every even data byte, slot 7 included
	task automatic test_aux_data_bits();
		repeat (3) send_word(32'hFEFE_FEFE);
		send_word(32'hFFFE_FEFE);
		release_push();
	endtask

	task automatic test_random(input int n_words);
		logic [BYTE_W-1:0] fb [16];
		int sent;
		sent = 0;
		while (sent < n_words) begin
			if ($urandom_range(0, 4) != 0) begin
				random_frame(fb);
				if ($urandom_range(0, 5) == 0)
					send_word(ALL_ONES);
				send_frame(fb, 1'b1);
				sent += 4;
			end else if ($urandom_range(0, 7) == 0) begin
				send_word(ALL_ONES);
			end else begin
				// stray word shifts the frame alignment
				send_word(fault_safe($urandom));
				sent++;
			end
		end
		release_push();
	endtask

	task automatic test_backpressure();
		logic [BYTE_W-1:0] fb [16];
		hold_off = 300;
		repeat (6) begin
			random_frame(fb);
			send_frame(fb, 1'b1);
		end
		release_push();
	endtask

	task automatic test_drain_pause();
		logic [BYTE_W-1:0] fb [16];
		repeat (2) begin
			random_frame(fb);
			send_frame(fb, 1'b1);
		end
		release_push();
		wait_results_done();
		repeat (2) begin
			random_frame(fb);
			send_frame(fb, 1'b1);
		end
		release_push();
	endtask

	// slot 7 ID change with aux set: fault result, then every word is ignored
	task automatic test_fault();
		logic [BYTE_W-1:0] fb [16];
		fb = '{8'h10, 8'h20, 8'h00, 8'hFF, 8'h03, 8'h31, 8'h42, 8'h53,
		       8'h64, 8'h75, 8'h86, 8'h97, 8'hA8, 8'hB9, 8'h0D, 8'h80};
		// stray words earlier may leave a partial frame; pad it out first
		while (held_words != 0)
			send_word(32'h0000_0000);
		send_frame(fb, 1'b0);
		repeat (4) send_word(32'h0000_0000);
		repeat (5) send_word($urandom);
		release_push();
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		word = '0;
		idle_en = 1'b1;
		hold_off = 0;
		fail_count = 0;
		cycle_count = 0;
		held_words = 0;
		cur_id = ID_RESET;
		stuck = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_plain_data();
		test_filler_words();
		test_id_changes();
		test_aux_data_bits();
		test_backpressure();
		test_random(80);
		test_drain_pause();
		idle_en = 1'b0;
		test_random(24);
		test_fault();

		wait_results_done();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
